// ===== rtl/bpoc_pkg.sv =====
// Shared types, constants and helpers for the byte pattern occurrence counter.
// Used by every module of the block; it depends on nothing else.
package bpoc_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int COUNT_WIDTH = 16;

  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] SINCE_SAT = LEN_W'(15);

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(1);

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_t;

  // Result of one buffer as seen by the output register.
  typedef struct packed {
    logic                   valid;
    logic [COUNT_WIDTH-1:0] count;
    logic                   status;
  } res_t;

  // A length of zero counts as one, anything beyond the window is clamped.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] n;
    n = raw;
    if (n == '0) begin
      n = LEN_W'(1);
    end
    if (n > LEN_W'(PATTERN_MAX)) begin
      n = LEN_W'(PATTERN_MAX);
    end
    return n;
  endfunction

endpackage

// ===== rtl/bpoc_cell.sv =====
// One window cell: holds one byte of the recent-byte window and compares the
// byte it takes on with the pattern byte for its position. Uses bpoc_pkg.
module bpoc_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bpoc_pkg::IDX_W-1:0]  idx,
  input  logic [bpoc_pkg::LEN_W-1:0]  len,
  input  bpoc_pkg::pat_t              pat,
  input  logic [bpoc_pkg::BYTE_W-1:0] din,
  output logic [bpoc_pkg::BYTE_W-1:0] dout,
  output logic                        hit
);

  logic [bpoc_pkg::BYTE_W-1:0] byte_r;
  logic [bpoc_pkg::LEN_W-1:0]  pos;

  // Window entry idx is compared with pattern byte len-1-idx.
  assign pos = len - bpoc_pkg::LEN_W'(idx) - bpoc_pkg::LEN_W'(1);

  always_comb begin
    if (bpoc_pkg::LEN_W'(idx) >= len) begin
      hit = 1'b1;
    end else begin
      hit = (din == pat[pos[bpoc_pkg::IDX_W-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_r <= din;
    end
  end

  assign dout = byte_r;

endmodule

// ===== rtl/bpoc_count.sv =====
// Buffer counters: bytes in the buffer, bytes since the last counted match and
// the saturating match count; forms the result on the last byte. Uses bpoc_pkg.
module bpoc_count (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       last,
  input  logic                       all_hit,
  input  logic [bpoc_pkg::LEN_W-1:0] len,
  output bpoc_pkg::res_t             res
);

  localparam logic [bpoc_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [bpoc_pkg::LEN_W-1:0]       bytes_in_r, bytes_in_nxt;
  logic [bpoc_pkg::LEN_W-1:0]       since_r, since_nxt;
  logic [bpoc_pkg::COUNT_WIDTH-1:0] matches_r, matches_nxt;
  logic [bpoc_pkg::LEN_W-1:0]       bytes_in_inc, since_inc;
  logic [bpoc_pkg::COUNT_WIDTH-1:0] matches_inc;
  logic                             match;

  always_comb begin
    bytes_in_inc = bytes_in_r;
    if (bytes_in_r < bpoc_pkg::SINCE_SAT) begin
      bytes_in_inc = bytes_in_r + bpoc_pkg::LEN_W'(1);
    end
    since_inc = since_r;
    if (since_r < bpoc_pkg::SINCE_SAT) begin
      since_inc = since_r + bpoc_pkg::LEN_W'(1);
    end

    // Greedy scan: a match counts only once a full pattern length has
    // arrived since the buffer start or the end of the previous match.
    match = all_hit && (since_inc >= len);

    matches_inc = matches_r;
    if (match && (matches_r != COUNT_MAX)) begin
      matches_inc = matches_r + bpoc_pkg::COUNT_WIDTH'(1);
    end

    res.valid  = accept && last;
    res.status = (bytes_in_inc < len) ? bpoc_pkg::STATUS_SHORT : bpoc_pkg::STATUS_OK;
    res.count  = (bytes_in_inc < len) ? '0 : matches_inc;

    bytes_in_nxt = bytes_in_r;
    since_nxt    = since_r;
    matches_nxt  = matches_r;
    if (accept) begin
      if (last) begin
        bytes_in_nxt = '0;
        since_nxt    = '0;
        matches_nxt  = '0;
      end else begin
        bytes_in_nxt = bytes_in_inc;
        since_nxt    = match ? '0 : since_inc;
        matches_nxt  = matches_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_r <= '0;
      since_r    <= '0;
      matches_r  <= '0;
    end else begin
      bytes_in_r <= bytes_in_nxt;
      since_r    <= since_nxt;
      matches_r  <= matches_nxt;
    end
  end

endmodule

// ===== rtl/byte_pattern_occurrence_counter.sv =====
// Byte pattern occurrence counter: counts non-overlapping pattern matches.
// One byte word is accepted every cycle while in_stall is low; the window compare
// runs across the cell chain in parallel and the counters update in the same cycle.
// The result appears on out_valid in the cycle after the last byte is accepted.
// A full output register holds off new bytes only while out_stall is high.
// Synchronous reset clears counters, pattern (zero) and length (one).
module byte_pattern_occurrence_counter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bpoc_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             in_last_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bpoc_pkg::COUNT_WIDTH-1:0] out_match_count,
  output logic                             out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpoc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpoc_pkg::PAT_W-1:0]       cfg_data
);

  logic [bpoc_pkg::PAT_W-1:0]       pattern_r;
  logic [bpoc_pkg::LEN_W-1:0]       length_r;
  logic [bpoc_pkg::LEN_W-1:0]       len;
  bpoc_pkg::pat_t                   pat;
  logic                             accept;
  logic [bpoc_pkg::BYTE_W-1:0]      chain [bpoc_pkg::PATTERN_MAX+1];
  logic [bpoc_pkg::PATTERN_MAX-1:0] hits;
  bpoc_pkg::res_t                   res;
  logic                             out_valid_r;
  logic [bpoc_pkg::COUNT_WIDTH-1:0] count_r;
  logic                             status_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= bpoc_pkg::LEN_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        bpoc_pkg::REG_PATTERN_BYTES:  pattern_r <= cfg_data;
        bpoc_pkg::REG_PATTERN_LENGTH: length_r  <= cfg_data[bpoc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len = bpoc_pkg::eff_len(length_r);
  assign pat = bpoc_pkg::pat_t'(pattern_r[bpoc_pkg::PATTERN_MAX*bpoc_pkg::BYTE_W-1:0]);

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign chain[0] = in_data_byte;

  for (genvar j = 0; j < bpoc_pkg::PATTERN_MAX; j++) begin : g_cell
    bpoc_cell u_cell (
      .clk  (clk),
      .en   (accept),
      .idx  (bpoc_pkg::IDX_W'(j)),
      .len  (len),
      .pat  (pat),
      .din  (chain[j]),
      .dout (chain[j+1]),
      .hit  (hits[j])
    );
  end

  bpoc_count u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .last    (in_last_byte),
    .all_hit (&hits),
    .len     (len),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      count_r  <= res.count;
      status_r <= res.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = count_r;
  assign out_status      = status_r;

endmodule

// ===== bench/bpoc_checker.sv =====
// Checker for the byte pattern occurrence counter: follows the input, result and
// register channels, predicts each buffer's tally and compares it with the result.
// Depends on bpoc_pkg for widths, register indexes and status codes.
module bpoc_checker
  import bpoc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_data_byte,
  input  logic                   in_last_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [COUNT_WIDTH-1:0] out_match_count,
  input  logic                   out_status,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PAT_W-1:0]       cfg_data,
  output int                     pending,
  output int                     failures
);

  typedef struct {
    logic [COUNT_WIDTH-1:0] count;
    logic                   status;
  } tally_t;

  tally_t expected_tallies[$];
  int     mismatches = 0;

  // Shadow of the block: register copies and per-buffer scan state.
  logic [PAT_W-1:0]       pattern_reg;
  logic [LEN_W-1:0]       length_reg;
  logic [BYTE_W-1:0]      recent_bytes [PATTERN_MAX];
  logic [LEN_W-1:0]       since_match;
  logic [LEN_W-1:0]       buffer_bytes;
  logic [COUNT_WIDTH-1:0] match_total;

  initial pending = 0;
  assign failures = mismatches;

  task automatic clear_scan();
    for (int i = 0; i < PATTERN_MAX; i++) begin
      recent_bytes[i] = '0;
    end
    since_match  = '0;
    buffer_bytes = '0;
    match_total  = '0;
  endtask

  // Shifts one byte into the window and counts a match ending here when
  // enough bytes have passed since the start or the previous match.
  task automatic count_byte(input logic [BYTE_W-1:0] data, input logic last);
    int     used;
    bit     hit;
    tally_t tally;
    used = (length_reg == '0) ? 1 :
           ((length_reg > LEN_W'(PATTERN_MAX)) ? PATTERN_MAX : int'(length_reg));
    for (int i = PATTERN_MAX - 1; i > 0; i--) begin
      recent_bytes[i] = recent_bytes[i-1];
    end
    recent_bytes[0] = data;
    if (buffer_bytes != SINCE_SAT) begin
      buffer_bytes++;
    end
    if (since_match != SINCE_SAT) begin
      since_match++;
    end
    hit = (int'(since_match) >= used);
    for (int k = 0; k < used; k++) begin
      if (recent_bytes[used-1-k] != pattern_reg[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
    if (hit) begin
      if (match_total != '1) begin
        match_total++;
      end
      since_match = '0;
    end
    if (last) begin
      if (int'(buffer_bytes) < used) begin
        tally.count  = '0;
        tally.status = STATUS_SHORT;
      end else begin
        tally.count  = match_total;
        tally.status = STATUS_OK;
      end
      expected_tallies.push_back(tally);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    tally_t want;
    if (!rst_n) begin
      pattern_reg = '0;
      length_reg  = LEN_W'(1);
      clear_scan();
      expected_tallies.delete();
    end else begin
      // Results are registered and leave after their last byte, so check first.
      if (out_valid && !out_stall) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: result with none expected: count %0d status %0d",
                   $time, out_match_count, out_status);
          mismatches++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_match_count !== want.count) begin
            $display("%0t: match_count expected %0d, got %0d",
                     $time, want.count, out_match_count);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, out_status);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_BYTES:  pattern_reg = cfg_data;
          REG_PATTERN_LENGTH: length_reg  = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        count_byte(in_data_byte, in_last_byte);
      end
    end
    pending <= expected_tallies.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the bench for the byte pattern occurrence counter: clock, reset,
// byte buffers, register writes and result stalls, plus the final verdict.
// Depends on bpoc_pkg, the counter itself and bpoc_checker.
module tb_top;
  import bpoc_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_BYTES = 1250;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_data_byte = '0;
  logic                   in_last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [COUNT_WIDTH-1:0] out_match_count;
  logic                   out_status;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [PAT_W-1:0]       cfg_data = '0;

  int pending;
  int failures;
  int stall_hold = 0;
  bit no_idle = 1'b0;
  int bytes_sent = 0;

  // Pattern in use, kept so that buffers can be built from its bytes.
  logic [PAT_W-1:0] cur_pattern = '0;
  int               cur_used = 1;

  byte_pattern_occurrence_counter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_match_count(out_match_count), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bpoc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_match_count(out_match_count), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Result stalls come in runs of random length, high or low.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < 30);
      stall_hold <= pick_gap();
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // The caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, PAT_W'(len));
    cfg_valid   <= 1'b0;
    cur_pattern = pat;
    cur_used    = (len == '0) ? 1 : ((len > LEN_W'(PATTERN_MAX)) ? PATTERN_MAX : int'(len));
  endtask

  // Lets every expected result out, then idles for any bytes still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Builds a buffer mostly from pattern bytes in order, so that matches,
  // near misses and overlaps are common; a noisy buffer is random bytes.
  task automatic send_buffer(input int n, input bit closed);
    int               pos;
    int               r;
    bit               noisy;
    logic [BYTE_W-1:0] b;
    pos   = 0;
    noisy = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (noisy || r >= 8) begin
        b = BYTE_W'($urandom);
      end else if (r < 5) begin
        b   = cur_pattern[8*pos +: 8];
        pos = (pos + 1) % cur_used;
      end else begin
        b = cur_pattern[8*$urandom_range(0, cur_used - 1) +: 8];
        if (r == 7) begin
          pos = 0;
        end
      end
      send_byte(b, closed && (i == n - 1));
    end
  endtask

  initial begin : stimulus
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] len;
    int               r;
    int               n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Values after reset: pattern of one zero byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // A length of zero counts as one.
    configure(64'hA5A5_5A5A_C3C3_003C, 4'd0);
    send_byte(8'h3C, 1'b1);
    drain();

    // Full window of eight bytes, oldest byte against the first pattern byte.
    configure(64'h8877_6655_4433_2211, 4'd8);
    for (int i = 1; i <= 8; i++) begin
      send_byte(BYTE_W'(8'h11 * i), i == 8);
    end
    drain();

    // Writes to the unused indexes change nothing; then a short buffer.
    write_reg(REG_SPARE_A, {$urandom, $urandom});
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_byte(8'h11, 1'b1);
    drain();

    // Upper pattern bits beyond the length are ignored; greedy, no overlap.
    configure(64'hDEAD_BEEF_0BAD_4141, 4'd2);
    repeat (3) send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);
    drain();

    // Pattern change in the middle of a buffer keeps window and counters.
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    drain();
    configure(64'h1234_5678_9ABC_FF00, 4'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // A length above the window is clamped to eight.
    configure(64'h0, 4'd15);
    for (int i = 0; i < 8; i++) begin
      send_byte(8'h00, i == 7);
    end
    drain();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 5);
      if (r == 0) begin
        pat = '0;
      end else if (r == 1) begin
        pat = '1;
      end else if (r == 2) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
          pat[8*k +: 8] = ($urandom_range(0, 1) == 0) ? 8'h41 : 8'h42;
        end
      end else begin
        pat = {$urandom, $urandom};
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        len = '0;
      end else if (r == 1) begin
        len = LEN_W'($urandom_range(9, 15));
      end else if (r == 2) begin
        len = LEN_W'(PATTERN_MAX);
      end else if (r == 3) begin
        len = LEN_W'(1);
      end else begin
        len = LEN_W'($urandom_range(1, PATTERN_MAX));
      end
      configure(pat, len);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
        cfg_valid <= 1'b0;
      end
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 8)) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          n = $urandom_range(1, cur_used);
        end else if (r == 1) begin
          n = $urandom_range(16, 30);
        end else begin
          n = $urandom_range(cur_used, 3 * cur_used + 2);
        end
        send_buffer(n, 1'b1);
      end
      // Sometimes leave a buffer open across the next register write.
      if ($urandom_range(0, 3) == 0) begin
        send_buffer($urandom_range(1, 6), 1'b0);
      end
      drain();
    end

    // Close any buffer left open so that its tally is checked too.
    send_buffer($urandom_range(1, 4), 1'b1);
    drain();

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
